/* rtl/core/wsm_pkg.sv */
// Package for the wildcard string matcher.
// Holds the fixed field widths, the operation codes and the cell control struct.
// No dependencies; every other file of the block but wsm_out_if imports it.
package wsm_pkg;

  localparam int OP_W  = 2;
  localparam int SYM_W = 5;
  localparam int IDX_W = 6;
  localparam int CFG_W = 7;

  localparam logic [SYM_W-1:0] SYM_WILDCARD = '0;
  localparam logic [CFG_W-1:0] LEN_RESET    = CFG_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_NEW  = 2'd2
  } op_t;

  // Controls broadcast to every cell of the row.
  typedef struct packed {
    logic shift;   // take the neighbour's text symbol and refresh the hit flag
    logic clear;   // empty the text window
    logic rot_up;  // pattern symbol moves from cell k-1 into cell k
    logic rot_dn;  // pattern symbol moves from cell k+1 into cell k
  } cell_ctrl_t;

endpackage

/* rtl/core/wsm_in_if.sv */
// Request channel of the wildcard string matcher: valid/ready plus item fields.
// Depends on wsm_pkg for the field widths.
interface wsm_in_if import wsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SYM_W-1:0] symbol;
  logic [IDX_W-1:0] pattern_index;

  modport source (output valid, operation, symbol, pattern_index, input ready);
  modport sink   (input valid, operation, symbol, pattern_index, output ready);
endinterface

/* rtl/core/wsm_out_if.sv */
// Result channel of the wildcard string matcher: valid/ready plus position and count.
// Depends on nothing; the field width follows the POSITION_BITS parameter.
interface wsm_out_if #(parameter int POSITION_BITS = 20) ();
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] start_position;
  logic [POSITION_BITS-1:0] match_count;

  modport source (output valid, start_position, match_count, input ready);
  modport sink   (input valid, start_position, match_count, output ready);
endinterface

/* rtl/core/wsm_cell.sv */
// One cell of the matcher row: one text window symbol, one pattern symbol, one hit flag.
// Depends on wsm_pkg for the symbol width and the cell control struct.
module wsm_cell import wsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic             load_en,
  input  logic [SYM_W-1:0] load_sym,
  input  logic [SYM_W-1:0] text_in,
  input  logic [SYM_W-1:0] pat_up_in,
  input  logic [SYM_W-1:0] pat_dn_in,
  input  logic             active,
  output logic [SYM_W-1:0] win_o,
  output logic [SYM_W-1:0] pat_o,
  output logic             hit_o
);

  logic [SYM_W-1:0] win_r, win_nxt;
  logic [SYM_W-1:0] pat_r, pat_nxt;
  logic             hit_r, hit_nxt;

  always_comb begin
    win_nxt = win_r;
    if (ctrl.clear) begin
      win_nxt = SYM_WILDCARD;
    end else if (ctrl.shift) begin
      win_nxt = text_in;
    end

    pat_nxt = pat_r;
    if (load_en) begin
      pat_nxt = load_sym;
    end else if (ctrl.rot_up) begin
      pat_nxt = pat_up_in;
    end else if (ctrl.rot_dn) begin
      pat_nxt = pat_dn_in;
    end

    // The incoming text symbol is compared against the pattern as it stands
    // before any load in the same cycle.
    hit_nxt = hit_r;
    if (ctrl.shift) begin
      hit_nxt = !active || pat_r == SYM_WILDCARD || text_in == SYM_WILDCARD ||
                pat_r == text_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= SYM_WILDCARD;
    end else begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    hit_r <= hit_nxt;
  end

  assign win_o = win_r;
  assign pat_o = pat_r;
  assign hit_o = hit_r;

endmodule

/* rtl/core/wsm_row.sv */
// Row of matcher cells wired as a shift chain, with the reduction of the hit flags.
// Depends on wsm_pkg and instantiates wsm_cell.
module wsm_row import wsm_pkg::*; #(
  parameter int PATTERN_MAX = 64,
  parameter int LW          = $clog2(PATTERN_MAX + 1),
  parameter int AW          = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic             load_en,
  input  logic [AW-1:0]    load_addr,
  input  logic [SYM_W-1:0] load_sym,
  input  logic [SYM_W-1:0] text_sym,
  input  logic [LW-1:0]    len,
  output logic             match
);

  logic [SYM_W-1:0] win [PATTERN_MAX];
  logic [SYM_W-1:0] pat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit;

  // Cell k sees the text symbol that is k places older than the newest one,
  // and holds the pattern symbol that belongs to that window place.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [SYM_W-1:0] text_in;
    if (k == 0) begin : g_head
      assign text_in = text_sym;
    end else begin : g_body
      assign text_in = win[k-1];
    end

    wsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load_en   (load_en && load_addr == AW'(k)),
      .load_sym  (load_sym),
      .text_in   (text_in),
      .pat_up_in (pat[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
      .pat_dn_in (pat[(k + 1) % PATTERN_MAX]),
      .active    (len > LW'(k)),
      .win_o     (win[k]),
      .pat_o     (pat[k]),
      .hit_o     (hit[k])
    );
  end

  assign match = &hit;

endmodule

/* rtl/core/wildcard_string_matcher.sv */
// Top level of the wildcard string matcher: handshakes, counters and pattern alignment.
// Depends on wsm_pkg, wsm_in_if, wsm_out_if and wsm_row.
//
//   Channel   Direction  Handshake                 Contents
//   in_chan   sink       valid/ready               operation, symbol, pattern_index
//   out_chan  source     valid/ready               start_position, match_count
//   cfg_*     sink       cfg_wr_en (no wait)       pattern_length
//
// A new request is taken every cycle while results drain and no realignment is under way.
// A text compare is held in the s1 register, then posted from the out register.
// After a pattern_length write the row rotates the pattern one place per cycle,
// until it has shifted by the change in length, and takes no request meanwhile.
// A stalled result holds one pending compare; further requests wait behind it.
// Reset (rst_n low, synchronous) empties the window, zeroes the counters, sets length 1.
module wildcard_string_matcher import wsm_pkg::*; #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  wsm_in_if.sink           in_chan,
  wsm_out_if.source        out_chan,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int LW  = $clog2(PATTERN_MAX + 1);
  localparam int AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int XW  = (LW > CFG_W) ? LW : CFG_W;
  localparam int XW2 = ((LW > IDX_W) ? LW : IDX_W) + 1;
  localparam int CW  = ((POSITION_BITS > LW) ? POSITION_BITS : LW) + 1;
  localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

  logic [CFG_W-1:0]         cfg_len_r;
  logic [LW-1:0]            align_r, align_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [POSITION_BITS-1:0] found_r, found_nxt, found_inc;
  logic                     s1_valid_r, s1_valid_nxt;
  logic [POSITION_BITS-1:0] s1_start_r, s1_start_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [POSITION_BITS-1:0] out_start_r, out_start_nxt;
  logic [POSITION_BITS-1:0] out_count_r, out_count_nxt;

  logic [XW-1:0]  cfg_x;
  logic [LW-1:0]  tgt_len;
  logic           busy;
  logic [XW2-1:0] a1, ix, wdist;
  logic [AW-1:0]  load_addr;
  logic           idx_ok;
  logic           acc, s2_go, match;
  op_t            op;
  cell_ctrl_t     ctrl;
  logic           load_en;
  logic [CW-1:0]  start_w;

  // Pattern length as used: zero counts as one, anything beyond the row as the full row.
  always_comb begin
    cfg_x = XW'(cfg_len_r);
    if (cfg_x == '0) begin
      tgt_len = LW'(1);
    end else if (cfg_x > XW'(PATTERN_MAX)) begin
      tgt_len = LW'(PATTERN_MAX);
    end else begin
      tgt_len = LW'(cfg_x);
    end
  end

  assign busy = align_r != tgt_len;

  // Pattern symbol j lives in cell (len - 1 - j) modulo the row length.
  always_comb begin
    a1 = XW2'(align_r) - XW2'(1);
    ix = XW2'(in_chan.pattern_index);
    if (a1 >= ix) begin
      wdist = a1 - ix;
    end else begin
      wdist = a1 + XW2'(PATTERN_MAX) - ix;
    end
    load_addr = AW'(wdist);
    idx_ok    = ix < XW2'(PATTERN_MAX);
  end

  assign s2_go          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !busy && (!s1_valid_r || s2_go);
  assign acc            = in_chan.valid && in_chan.ready;
  assign op             = op_t'(in_chan.operation);

  assign pos_inc   = (pos_r == COUNT_MAX) ? pos_r : pos_r + POSITION_BITS'(1);
  assign found_inc = (found_r == COUNT_MAX) ? found_r : found_r + POSITION_BITS'(1);
  assign start_w   = CW'(pos_inc) - CW'(align_r) + CW'(1);

  always_comb begin
    ctrl          = '0;
    load_en       = 1'b0;
    align_nxt     = align_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    s1_valid_nxt  = s1_valid_r;
    s1_start_nxt  = s1_start_r;
    out_valid_nxt = out_valid_r;
    out_start_nxt = out_start_r;
    out_count_nxt = out_count_r;

    if (busy) begin
      if (tgt_len > align_r) begin
        ctrl.rot_up = 1'b1;
        align_nxt   = align_r + LW'(1);
      end else begin
        ctrl.rot_dn = 1'b1;
        align_nxt   = align_r - LW'(1);
      end
    end

    // Second stage: reduce the hit flags, count a match and post it as a result.
    if (s2_go) begin
      s1_valid_nxt = 1'b0;
      out_valid_nxt = match;
      if (match) begin
        found_nxt     = found_inc;
        out_start_nxt = s1_start_r;
        out_count_nxt = found_inc;
      end
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (acc) begin
      case (op)
        OP_LOAD: begin
          load_en = idx_ok;
        end
        OP_TEXT: begin
          ctrl.shift   = 1'b1;
          pos_nxt      = pos_inc;
          s1_start_nxt = POSITION_BITS'(start_w);
          s1_valid_nxt = CW'(pos_inc) >= CW'(align_r);
        end
        OP_NEW: begin
          ctrl.clear = 1'b1;
          pos_nxt    = '0;
          found_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  wsm_row #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .load_en   (load_en),
    .load_addr (load_addr),
    .load_sym  (in_chan.symbol),
    .text_sym  (in_chan.symbol),
    .len       (align_r),
    .match     (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= LEN_RESET;
      align_r     <= LW'(1);
      pos_r       <= '0;
      found_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      align_r     <= align_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_start_r  <= s1_start_nxt;
    out_start_r <= out_start_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.start_position = out_start_r;
  assign out_chan.match_count    = out_count_r;

  // No request may be taken while the pattern is being realigned.
  a_no_accept_while_rotating: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_chan.ready)
    else $error("request accepted during pattern realignment");

  // A posted result always carries a count of at least one.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r != '0)
    else $error("result posted with zero match count");

  // A pending compare always has a start position of at least one.
  a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_start_r != '0)
    else $error("pending compare with zero start position");

  // The matches found can only grow by one on a posted result.
  a_found_step: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r != $past(found_r) && found_r != '0) |-> out_valid_r)
    else $error("match count moved without a result");

endmodule
